// ===== sv/swr_pkg.sv =====
package swr_pkg;

    // stack geometry
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // field widths
    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 5;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // value returned by a pop on an empty stack
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_SCAN,
        S_SHIFT
    } t_state;

    // port request into the entry memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // completion of one command
    typedef struct packed {
        logic               vld;
        logic [DATA_W-1:0]  result;
        t_status            status;
        logic [LEVEL_W-1:0] level;
    } t_done;

endpackage

// ===== sv/swr_ram.sv =====
module swr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/swr_ctrl.sv =====
module swr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  swr_pkg::t_cmd               i_cmd,
    input  logic [swr_pkg::DATA_W-1:0]  i_value,
    output logic                        o_busy,
    output swr_pkg::t_mem_req           o_mem,
    input  logic [swr_pkg::DATA_W-1:0]  i_rdata,
    output swr_pkg::t_done              o_done
);
    import swr_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [DATA_W-1:0]  r_key, n_key;

    logic [CNT_W-1:0]   w_cnt_m1;
    logic [CNT_W-1:0]   w_idx_p1;
    logic [CNT_W-1:0]   w_idx_p2;
    logic               w_full;
    logic               w_empty;
    logic               w_hit;

    // shared compare unit and index arithmetic
    assign w_cnt_m1 = r_count - CNT_W'(1);
    assign w_idx_p1 = CNT_W'(r_idx) + CNT_W'(1);
    assign w_idx_p2 = CNT_W'(r_idx) + CNT_W'(2);
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_hit    = (i_rdata == r_key);

    assign o_busy = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_cmd == CMD_POP && !w_empty) begin
                        n_state = S_POP_RD;
                    end else if (i_cmd == CMD_REMOVE && !w_empty) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_POP_RD: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = (w_idx_p1 == r_count) ? S_IDLE : S_SHIFT;
                end else if (r_idx == '0) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (w_idx_p2 == r_count) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count        = r_count;
        n_idx          = r_idx;
        n_key          = r_key;
        o_mem.we       = 1'b0;
        o_mem.waddr    = r_idx;
        o_mem.wdata    = i_rdata;
        o_mem.raddr    = r_idx;
        o_done.vld     = 1'b0;
        o_done.result  = '0;
        o_done.status  = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_cmd)
                        CMD_PUSH: begin
                            o_done.vld = 1'b1;
                            if (w_full) begin
                                o_done.status = ST_FULL;
                            end else begin
                                o_mem.we    = 1'b1;
                                o_mem.waddr = r_count[ADDR_W-1:0];
                                o_mem.wdata = i_value;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP: begin
                            if (w_empty) begin
                                o_done.vld    = 1'b1;
                                o_done.result = EMPTY_VALUE;
                                o_done.status = ST_EMPTY;
                            end else begin
                                o_mem.raddr = w_cnt_m1[ADDR_W-1:0];
                                n_count     = w_cnt_m1;
                            end
                        end
                        CMD_REMOVE: begin
                            n_key = i_value;
                            if (w_empty) begin
                                o_done.vld    = 1'b1;
                                o_done.status = ST_NOT_FOUND;
                            end else begin
                                o_mem.raddr = w_cnt_m1[ADDR_W-1:0];
                                n_idx       = w_cnt_m1[ADDR_W-1:0];
                            end
                        end
                        CMD_NOP: begin
                            o_done.vld = 1'b1;
                        end
                        default: o_done.vld = 1'b1;
                    endcase
                end
            end
            S_POP_RD: begin
                o_done.vld    = 1'b1;
                o_done.result = i_rdata;
            end
            // walk down from the top, one entry per cycle
            S_SCAN: begin
                if (w_hit) begin
                    if (w_idx_p1 == r_count) begin
                        n_count    = w_cnt_m1;
                        o_done.vld = 1'b1;
                    end else begin
                        o_mem.raddr = w_idx_p1[ADDR_W-1:0];
                    end
                end else if (r_idx == '0) begin
                    o_done.vld    = 1'b1;
                    o_done.status = ST_NOT_FOUND;
                end else begin
                    o_mem.raddr = r_idx - ADDR_W'(1);
                    n_idx       = r_idx - ADDR_W'(1);
                end
            end
            // move each entry above the hit down by one place
            S_SHIFT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = i_rdata;
                if (w_idx_p2 == r_count) begin
                    n_count    = w_cnt_m1;
                    o_done.vld = 1'b1;
                end else begin
                    o_mem.raddr = w_idx_p2[ADDR_W-1:0];
                    n_idx       = w_idx_p1[ADDR_W-1:0];
                end
            end
            default: begin
                o_done.vld = 1'b0;
            end
        endcase
        o_done.level = LEVEL_W'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // scan position and key
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_key <= n_key;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("command started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done.vld |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle after completion");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> CNT_W'(o_mem.waddr) <= r_count)
        else $error("write above the top of the stack");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> w_idx_p2 <= r_count)
        else $error("shift reads beyond held entries");
`endif

endmodule

// ===== sv/stack_with_remove_by_value.sv =====
// LIFO stack of signed 32-bit words with delete by value.
// Input channel: i_in_valid / o_in_ready with i_cmd (0 push, 1 pop,
// 2 remove nearest match from the top, 3 no operation) and i_value.
// Output channel: o_out_valid / i_out_ready with o_result_value, o_status
// (0 ok, 1 empty, 2 not found, 3 full and push dropped) and o_level.
// Every command gives exactly one result.
// Push, no-op and commands on an empty stack finish in the accept cycle
// and the result shows in the next cycle; pop finishes in the state after
// the accept, once the memory read returns; remove searches the entries
// from the top down, one entry per cycle, then moves each entry above the
// match down by one place, one entry per cycle.
// The single-port-read entry memory and its one compare unit set the rate.
// One command is in work at a time; the next is accepted once the block
// is idle and the result register is empty or being drained.
// Reset (synchronous, active low) empties the stack at once; no clearing
// pass is needed. While the receiver stalls, the result is held and no new
// command is accepted.
module stack_with_remove_by_value (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [swr_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [swr_pkg::DATA_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [swr_pkg::DATA_W-1:0]  o_result_value,
    output logic [swr_pkg::STAT_W-1:0]         o_status,
    output logic [swr_pkg::LEVEL_W-1:0]        o_level
);
    import swr_pkg::*;

    logic               w_busy;
    logic               w_start;
    t_mem_req           w_mem;
    t_done              w_done;
    logic [DATA_W-1:0]  w_rdata;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_result;
    t_status            r_status;
    logic [LEVEL_W-1:0] r_level;

    // accept when idle and the result slot is empty or frees this cycle
    assign o_in_ready = !w_busy && (!r_out_valid || i_out_ready);
    assign w_start    = i_in_valid && o_in_ready;

    swr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_cmd   (t_cmd'(i_cmd)),
        .i_value (i_value),
        .o_busy  (w_busy),
        .o_mem   (w_mem),
        .i_rdata (w_rdata),
        .o_done  (w_done)
    );

    swr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done.vld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_done.vld) begin
            r_result <= w_done.result;
            r_status <= w_done.status;
            r_level  <= w_done.level;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_level        = r_level;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done.vld |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before it was taken");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_in_ready)
        else $error("input accepted while a command is in work");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start && t_cmd'(i_cmd) == CMD_PUSH |-> w_done.vld)
        else $error("push did not complete in its accept cycle");
`endif

endmodule
